// File: hdl/rshc_pkg.sv
`default_nettype none

package rshc_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int HIT_COUNT_WIDTH = 16;
   localparam int HIT_COUNT_MAX   = (1 << HIT_COUNT_WIDTH) - 1;

   localparam int COORD_WIDTH = 24;
   localparam int DIR_WIDTH   = 16;
   localparam int SEMI_WIDTH  = 23;
   localparam int OFS_WIDTH   = COORD_WIDTH + 1;
   localparam int XP_WIDTH    = OFS_WIDTH + DIR_WIDTH;
   localparam int DIFF_WIDTH  = XP_WIDTH + 1;
   localparam int CROSS_WIDTH = XP_WIDTH;
   localparam int DXY_WIDTH   = 2 * DIR_WIDTH;
   localparam int DSQ_WIDTH   = DXY_WIDTH - 1;
   localparam int SQ_WIDTH    = 2 * SEMI_WIDTH;

   localparam int REQ_TDATA_WIDTH = 168;
   localparam int RSP_TDATA_WIDTH = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = COORD_WIDTH;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_Z = 2'd2;

   localparam int MAC_XW   = 84;
   localparam int MAC_YW   = 48;
   localparam int MAC_DW   = 12;
   localparam int MAC_NDIG = MAC_YW / MAC_DW;
   localparam int MAC_DIGW = $clog2(MAC_NDIG);
   localparam int MAC_PW   = MAC_XW + MAC_DW;
   localparam int MAC_AW   = MAC_XW + MAC_YW;
   localparam int MAC_NOPS = 9;
   localparam int MAC_OPW  = $clog2(MAC_NOPS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_PW + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic hit;
      logic last;
   } entry_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_PROD,
      FS_ABS,
      FS_MAC,
      FS_DRAIN,
      FS_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      XS_C1,
      XS_C2,
      XS_C3,
      XS_DXY,
      XS_DZZ,
      XS_T1,
      XS_T2,
      XS_T3,
      XS_T4
   } x_sel_type;

   typedef enum logic [2:0] {
      YS_C1,
      YS_C2,
      YS_C3,
      YS_H,
      YS_V
   } y_sel_type;

   typedef enum logic [2:0] {
      DS_NONE,
      DS_T1,
      DS_T2,
      DS_T3,
      DS_T4,
      DS_L,
      DS_CMP
   } dest_type;

   typedef struct packed {
      x_sel_type x_sel;
      y_sel_type y_sel;
      logic      accumulate;
      dest_type  dest;
   } mac_op_type;

   // lhs = (c1^2 + c2^2) * h + c3^2 * v, rhs = (dxy * h) * v + (dzz * h) * h
   function automatic mac_op_type mac_op(input logic [MAC_OPW-1:0] idx);
      mac_op_type op;
      case (idx)
         4'd0:    op = '{XS_C1,  YS_C1, 1'b0, DS_NONE};
         4'd1:    op = '{XS_C2,  YS_C2, 1'b1, DS_T1};
         4'd2:    op = '{XS_C3,  YS_C3, 1'b0, DS_T2};
         4'd3:    op = '{XS_DXY, YS_H,  1'b0, DS_T3};
         4'd4:    op = '{XS_DZZ, YS_H,  1'b0, DS_T4};
         4'd5:    op = '{XS_T1,  YS_H,  1'b0, DS_NONE};
         4'd6:    op = '{XS_T2,  YS_V,  1'b1, DS_L};
         4'd7:    op = '{XS_T3,  YS_V,  1'b0, DS_NONE};
         4'd8:    op = '{XS_T4,  YS_H,  1'b1, DS_CMP};
         default: op = '{XS_C1,  YS_C1, 1'b0, DS_NONE};
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// File: hdl/rshc_front.sv
`default_nettype none

module rshc_front
   import rshc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire point_type                  start,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   // dir_x, dir_y, dir_z, center_x, center_y, center_z, semi_horizontal, semi_vertical
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                       req_tlast,
   output      logic                       push_valid,
   input  wire logic                       push_ready,
   output      entry_type                  push_entry
);

   front_state_type state_ff, state_in;
   logic            load, issue, mac_done;

   logic [MAC_OPW-1:0]  op_ff, op_in;
   logic [MAC_DIGW-1:0] dig_ff, dig_in;

   logic signed [COORD_WIDTH-1:0] cen_x, cen_y, cen_z;
   logic [SEMI_WIDTH-1:0]         semi_h, semi_v;

   logic signed [OFS_WIDTH-1:0] px_ff, py_ff, pz_ff;
   logic signed [DIR_WIDTH-1:0] dx_ff, dy_ff, dz_ff;
   logic [SEMI_WIDTH-1:0]       rh_ff, rv_ff;
   logic                        last_ff, degen_ff;

   logic signed [XP_WIDTH-1:0] pydz_ff, pzdy_ff, pzdx_ff, pxdz_ff, pxdy_ff, pydx_ff;
   logic signed [XP_WIDTH-1:0] pydz_in, pzdy_in, pzdx_in, pxdz_in, pxdy_in, pydx_in;
   logic signed [DXY_WIDTH-1:0] dxx_full, dyy_full, dzz_full;
   logic [DSQ_WIDTH-1:0]        dxx_ff, dyy_ff, dzz_ff;
   logic [SQ_WIDTH-1:0]         h_ff, v_ff, h_in, v_in;

   logic signed [DIFF_WIDTH-1:0] e1, e2, e3;
   logic [CROSS_WIDTH-1:0]       c1_ff, c2_ff, c3_ff, c1_in, c2_in, c3_in;
   logic [DXY_WIDTH-1:0]         dxy_ff, dxy_in;

   mac_op_type          op_cur;
   logic [MAC_XW-1:0]   x_opnd;
   logic [MAC_YW-1:0]   y_opnd;
   logic [MAC_DW-1:0]   digit;
   logic [MAC_PW-1:0]   prod_ff, prod_in;
   logic [MAC_DIGW-1:0] prod_dig_ff;
   logic                prod_first_ff;
   dest_type            prod_dest_ff, prod_dest_in;
   logic [MAC_AW-1:0]   acc_ff, acc_in, acc_base, l_ff;
   logic [MAC_XW-1:0]   t1_ff, t2_ff, t3_ff, t4_ff;
   logic                hit_ff, hit_in;

   // control

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         FS_IDLE:  if (req_tvalid) state_in = FS_PROD;
         FS_PROD:  state_in = FS_ABS;
         FS_ABS:   state_in = FS_MAC;
         FS_MAC:   if (mac_done) state_in = FS_DRAIN;
         FS_DRAIN: state_in = FS_PUSH;
         FS_PUSH:  if (push_ready) state_in = FS_IDLE;
         default:  state_in = FS_IDLE;
      endcase
   end

   always_comb begin : state_outputs
      req_tready = 1'b0;
      issue      = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         FS_IDLE: req_tready = 1'b1;
         FS_MAC:  issue      = 1'b1;
         FS_PUSH: push_valid = 1'b1;
         default: ;
      endcase
   end

   assign load     = req_tvalid && req_tready;
   assign mac_done = (op_ff == MAC_OPW'(MAC_NOPS - 1)) && (dig_ff == MAC_DIGW'(MAC_NDIG - 1));

   always_comb begin : step_counters
      op_in  = op_ff;
      dig_in = dig_ff;
      if (state_ff == FS_ABS) begin
         op_in  = '0;
         dig_in = '0;
      end else if (issue) begin
         dig_in = dig_ff + MAC_DIGW'(1);
         if (dig_ff == MAC_DIGW'(MAC_NDIG - 1)) begin
            op_in = op_ff + MAC_OPW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_IDLE;
         op_ff        <= '0;
         dig_ff       <= '0;
         prod_dest_ff <= DS_NONE;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         dig_ff       <= dig_in;
         prod_dest_ff <= prod_dest_in;
      end
   end

   // item capture

   assign cen_x  = req_tdata[71:48];
   assign cen_y  = req_tdata[95:72];
   assign cen_z  = req_tdata[119:96];
   assign semi_h = req_tdata[142:120];
   assign semi_v = req_tdata[165:143];

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff    <= OFS_WIDTH'(start.x) - OFS_WIDTH'(cen_x);
         py_ff    <= OFS_WIDTH'(start.y) - OFS_WIDTH'(cen_y);
         pz_ff    <= OFS_WIDTH'(start.z) - OFS_WIDTH'(cen_z);
         dx_ff    <= req_tdata[15:0];
         dy_ff    <= req_tdata[31:16];
         dz_ff    <= req_tdata[47:32];
         rh_ff    <= semi_h;
         rv_ff    <= semi_v;
         last_ff  <= req_tlast;
         degen_ff <= (semi_h == '0) || (semi_v == '0);
      end
   end

   // cross products and squares

   always_comb begin : prod_stage
      pydz_in  = XP_WIDTH'(py_ff) * XP_WIDTH'(dz_ff);
      pzdy_in  = XP_WIDTH'(pz_ff) * XP_WIDTH'(dy_ff);
      pzdx_in  = XP_WIDTH'(pz_ff) * XP_WIDTH'(dx_ff);
      pxdz_in  = XP_WIDTH'(px_ff) * XP_WIDTH'(dz_ff);
      pxdy_in  = XP_WIDTH'(px_ff) * XP_WIDTH'(dy_ff);
      pydx_in  = XP_WIDTH'(py_ff) * XP_WIDTH'(dx_ff);
      dxx_full = DXY_WIDTH'(dx_ff) * DXY_WIDTH'(dx_ff);
      dyy_full = DXY_WIDTH'(dy_ff) * DXY_WIDTH'(dy_ff);
      dzz_full = DXY_WIDTH'(dz_ff) * DXY_WIDTH'(dz_ff);
      h_in     = SQ_WIDTH'(rh_ff) * SQ_WIDTH'(rh_ff);
      v_in     = SQ_WIDTH'(rv_ff) * SQ_WIDTH'(rv_ff);
   end

   always_ff @(posedge clock) begin
      pydz_ff <= pydz_in;
      pzdy_ff <= pzdy_in;
      pzdx_ff <= pzdx_in;
      pxdz_ff <= pxdz_in;
      pxdy_ff <= pxdy_in;
      pydx_ff <= pydx_in;
      dxx_ff  <= dxx_full[DSQ_WIDTH-1:0];
      dyy_ff  <= dyy_full[DSQ_WIDTH-1:0];
      dzz_ff  <= dzz_full[DSQ_WIDTH-1:0];
      h_ff    <= h_in;
      v_ff    <= v_in;
   end

   // magnitudes of the cross product and dx^2 + dy^2

   always_comb begin : abs_stage
      e1     = DIFF_WIDTH'(pydz_ff) - DIFF_WIDTH'(pzdy_ff);
      e2     = DIFF_WIDTH'(pzdx_ff) - DIFF_WIDTH'(pxdz_ff);
      e3     = DIFF_WIDTH'(pxdy_ff) - DIFF_WIDTH'(pydx_ff);
      c1_in  = e1[DIFF_WIDTH-1] ? CROSS_WIDTH'(-e1) : CROSS_WIDTH'(e1);
      c2_in  = e2[DIFF_WIDTH-1] ? CROSS_WIDTH'(-e2) : CROSS_WIDTH'(e2);
      c3_in  = e3[DIFF_WIDTH-1] ? CROSS_WIDTH'(-e3) : CROSS_WIDTH'(e3);
      dxy_in = DXY_WIDTH'(dxx_ff) + DXY_WIDTH'(dyy_ff);
   end

   always_ff @(posedge clock) begin
      c1_ff  <= c1_in;
      c2_ff  <= c2_in;
      c3_ff  <= c3_in;
      dxy_ff <= dxy_in;
   end

   // shared multiply-accumulate, one 12-bit digit of y per cycle

   assign op_cur = mac_op(op_ff);

   always_comb begin : operand_select
      case (op_cur.x_sel)
         XS_C1:   x_opnd = MAC_XW'(c1_ff);
         XS_C2:   x_opnd = MAC_XW'(c2_ff);
         XS_C3:   x_opnd = MAC_XW'(c3_ff);
         XS_DXY:  x_opnd = MAC_XW'(dxy_ff);
         XS_DZZ:  x_opnd = MAC_XW'(dzz_ff);
         XS_T1:   x_opnd = t1_ff;
         XS_T2:   x_opnd = t2_ff;
         XS_T3:   x_opnd = t3_ff;
         XS_T4:   x_opnd = t4_ff;
         default: x_opnd = '0;
      endcase
      case (op_cur.y_sel)
         YS_C1:   y_opnd = MAC_YW'(c1_ff);
         YS_C2:   y_opnd = MAC_YW'(c2_ff);
         YS_C3:   y_opnd = MAC_YW'(c3_ff);
         YS_H:    y_opnd = MAC_YW'(h_ff);
         YS_V:    y_opnd = MAC_YW'(v_ff);
         default: y_opnd = '0;
      endcase
      digit        = y_opnd[dig_ff*MAC_DW +: MAC_DW];
      prod_in      = MAC_PW'(x_opnd) * MAC_PW'(digit);
      prod_dest_in = (issue && dig_ff == MAC_DIGW'(MAC_NDIG - 1)) ? op_cur.dest : DS_NONE;
   end

   always_comb begin : accumulate
      acc_base = prod_first_ff ? '0 : acc_ff;
      acc_in   = acc_base + (MAC_AW'(prod_ff) << (MAC_DW * prod_dig_ff));
      hit_in   = !degen_ff && (l_ff <= acc_in);
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      prod_dig_ff   <= dig_ff;
      prod_first_ff <= (dig_ff == '0) && !op_cur.accumulate;
      acc_ff        <= acc_in;
      case (prod_dest_ff)
         DS_T1:   t1_ff  <= acc_in[MAC_XW-1:0];
         DS_T2:   t2_ff  <= acc_in[MAC_XW-1:0];
         DS_T3:   t3_ff  <= acc_in[MAC_XW-1:0];
         DS_T4:   t4_ff  <= acc_in[MAC_XW-1:0];
         DS_L:    l_ff   <= acc_in;
         DS_CMP:  hit_ff <= hit_in;
         default: ;
      endcase
   end

   assign push_entry = '{hit: hit_ff, last: last_ff};

endmodule

`default_nettype wire

// File: hdl/rshc_queue.sv
`default_nettype none

module rshc_queue
   import rshc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire entry_type in_entry,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      entry_type out_entry
);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;
   logic                  push, pop;

   assign in_ready  = cnt_ff != QUEUE_CW'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

`default_nettype wire

// File: hdl/rshc_back.sv
`default_nettype none

module rshc_back
   import rshc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       ent_valid,
   output      logic                       ent_ready,
   input  wire entry_type                  ent,
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   // hit_count
   output      logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int WideW = (COUNT_WIDTH > HIT_COUNT_WIDTH) ? COUNT_WIDTH : HIT_COUNT_WIDTH;

   logic [COUNT_WIDTH-1:0]     count_ff, count_in, bumped;
   logic [WideW-1:0]           wide;
   logic [HIT_COUNT_WIDTH-1:0] sat;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;
   logic                       take, emit;

   // only a last item needs the output register free
   assign ent_ready = !ent.last || !rsp_valid_ff || rsp_tready;
   assign take      = ent_valid && ent_ready;
   assign emit      = take && ent.last;

   always_comb begin
      bumped = (ent.hit && count_ff != '1) ? count_ff + COUNT_WIDTH'(1) : count_ff;
      wide   = WideW'(bumped);
      sat    = (wide > WideW'(HIT_COUNT_MAX)) ? '1 : wide[HIT_COUNT_WIDTH-1:0];
      count_in = count_ff;
      if (take) begin
         count_in = ent.last ? '0 : bumped;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= RSP_TDATA_WIDTH'(sat);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/ray_spheroid_hit_counter.sv
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata (direction, center, semi-axes), req_tlast
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata (hit count), one item per last spheroid
// csr      in   csr_wr_en              csr_index, csr_wdata (ray start point)
//
// a new item is accepted only after the previous one is pushed to the queue; the shared
// 84x12 multiply-accumulate unit steps through 9 products of 4 digits each per item
// the result is registered when the last item of a run leaves the queue
// synchronous reset clears the start point, the hit count and all control state
// up to 4 classified items wait in the queue while rsp is stalled

`default_nettype none

module ray_spheroid_hit_counter
   import rshc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   // dir_x, dir_y, dir_z, center_x, center_y, center_z, semi_horizontal,
   // semi_vertical, two zero bits
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                       req_tlast,
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   // hit_count
   output      logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   point_type start_ff;

   logic      q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   entry_type q_in_entry, q_out_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_X: start_ff.x <= csr_wdata;
            CSR_START_Y: start_ff.y <= csr_wdata;
            CSR_START_Z: start_ff.z <= csr_wdata;
            default:     ;
         endcase
      end
   end

   rshc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (q_in_valid),
      .push_ready (q_in_ready),
      .push_entry (q_in_entry)
   );

   rshc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_entry  (q_in_entry),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_entry (q_out_entry)
   );

   rshc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ent_valid  (q_out_valid),
      .ent_ready  (q_out_ready),
      .ent        (q_out_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_front_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("front took a second item right after an accept");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_out_valid && q_out_ready && q_out_entry.last))
      else $error("result appeared without a last item leaving the queue");

   a_last_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (q_out_valid && q_out_entry.last && rsp_tvalid && !rsp_tready) |-> !q_out_ready)
      else $error("last item taken while the output register is stalled");

endmodule

`default_nettype wire
